>>> rtl/snki_pkg.sv
package snki_pkg;

  localparam int SLOTS_DEF         = 16;
  localparam int MAX_KEY_BYTES_DEF = 8;

  localparam int KEY_LEN_W   = 4;
  localparam int TAG_W       = 8;
  localparam int PTR_W       = 64;
  localparam int IN_KEY_W    = 64;
  localparam int BYTE_SEL_W  = 3;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 4'd4;

  // register index (byte address / 4)
  localparam logic [CFG_AW-3:0] REG_KEY_LENGTH = '0;

  typedef enum logic [1:0] {
    ACT_PROBE  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_SPARE  = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  typedef struct packed {
    logic clear;
    logic take_left;
    logic load_new;
  } cell_ctl_t;

endpackage

>>> rtl/sorted_node_key_insert_unit.sv
// Sorted node key insert unit: holds one index-tree node as a row of slot
// cells (SLOTS searchable slots plus one overflow slot) and finds, for each
// input transaction, the first empty slot or first entry greater than the
// new (key, tag, pointer) entry.
// Input channel (in_*): action, key, file_number, record_pointer. Insert
// shifts the later slots up one cell and stores the entry; clear empties
// every cell and reports position 0; probe only reports.
// Output channel (out_*): position, one result per input transaction.
// The input is captured when accepted; in the busy state, once out_stall allows,
// all cells compare in parallel and shift in a single step and the result is
// registered. A new transaction is accepted only after the last one is applied.
// A finished result waits in the output register; the next input is still
// accepted then, but its update waits while out_stall holds that result.
// Reset empties the node and sets key_length to 4. The user must write key_length
// (cfg_* APB port, address 0) only while no transaction is open; unenforced.
module sorted_node_key_insert_unit #(
  parameter int SLOTS         = snki_pkg::SLOTS_DEF,
  parameter int MAX_KEY_BYTES = snki_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [snki_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [snki_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [snki_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_action,
  input  logic [snki_pkg::IN_KEY_W-1:0]      in_key,
  input  logic [snki_pkg::TAG_W-1:0]         in_file_number,
  input  logic signed [snki_pkg::PTR_W-1:0]  in_record_pointer,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [$clog2(SLOTS+1)-1:0]         out_position
);
  import snki_pkg::*;

  localparam int KEY_W = 8 * MAX_KEY_BYTES;
  localparam int POS_W = $clog2(SLOTS + 1);

  logic [KEY_LEN_W-1:0]  key_len_r;
  logic [KEY_LEN_W-1:0]  eff_len;
  logic [BYTE_SEL_W-1:0] byte_sel;
  logic [KEY_W-1:0]      key_mask;

  state_t state_r, state_nxt;
  logic   in_fire, apply;

  action_t          act_r;
  logic [KEY_W-1:0] item_key_r;
  logic [TAG_W-1:0] item_tag_r;
  logic [PTR_W-1:0] item_ptr_r;

  logic             out_valid_r;
  logic [POS_W-1:0] out_pos_r;
  logic [POS_W-1:0] pos;

  logic [KEY_W-1:0] cell_key [SLOTS+1];
  logic [TAG_W-1:0] cell_tag [SLOTS+1];
  logic [PTR_W-1:0] cell_ptr [SLOTS+1];
  logic [SLOTS:0]   hit;
  logic [SLOTS:0]   hit_eff;
  logic [SLOTS+1:0] found;
  cell_ctl_t        ctl [SLOTS+1];
  logic             do_clear, do_insert;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= KEY_LEN_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[CFG_AW-1:2] == REG_KEY_LENGTH) begin
      key_len_r <= cfg_pwdata[KEY_LEN_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_AW-1:2] == REG_KEY_LENGTH) begin
      cfg_prdata = CFG_DW'(key_len_r);
    end
  end

  assign cfg_pready = 1'b1;

  // zero acts as one byte, anything above the maximum as the maximum
  always_comb begin
    if (key_len_r == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_len_r > KEY_LEN_W'(MAX_KEY_BYTES)) begin
      eff_len = KEY_LEN_W'(MAX_KEY_BYTES);
    end else begin
      eff_len = key_len_r;
    end
    byte_sel = BYTE_SEL_W'(eff_len - KEY_LEN_W'(1));
    for (int b = 0; b < MAX_KEY_BYTES; b++) begin
      key_mask[8*b +: 8] = (KEY_LEN_W'(b) < eff_len) ? 8'hFF : 8'h00;
    end
  end

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (apply) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    apply    = (state_r == ST_BUSY) && (!out_valid_r || !out_stall);
  end

  assign in_fire = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item capture: key masked, tag is file_number+1 unless the trailer is all zero
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r      <= action_t'(in_action);
      item_key_r <= in_key[KEY_W-1:0] & key_mask;
      item_ptr_r <= PTR_W'(in_record_pointer);
      if (in_file_number != '0 || in_record_pointer != '0) begin
        item_tag_r <= in_file_number + TAG_W'(1);
      end else begin
        item_tag_r <= '0;
      end
    end
  end

  // ---------------- cell row ----------------
  assign do_clear  = apply && (act_r == ACT_CLEAR);
  assign do_insert = apply && (act_r == ACT_INSERT);

  assign found[0] = 1'b0;

  for (genvar j = 0; j <= SLOTS; j++) begin : g_cell
    logic [KEY_W-1:0] lk;
    logic [TAG_W-1:0] lt;
    logic [PTR_W-1:0] lp;

    if (j == 0) begin : g_head
      assign lk = '0;
      assign lt = '0;
      assign lp = '0;
    end else begin : g_link
      assign lk = cell_key[j-1];
      assign lt = cell_tag[j-1];
      assign lp = cell_ptr[j-1];
    end

    // overflow cell is never searched: it takes the entry when nothing else does
    if (j == SLOTS) begin : g_spare
      assign hit_eff[j] = 1'b1;
    end else begin : g_slot
      assign hit_eff[j] = hit[j];
    end

    assign found[j+1] = found[j] | hit_eff[j];

    always_comb begin
      ctl[j].clear     = do_clear;
      ctl[j].take_left = do_insert && found[j];
      ctl[j].load_new  = do_insert && !found[j] && hit_eff[j];
    end

    snki_cell #(
      .KEY_W (KEY_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[j]),
      .key_mask  (key_mask),
      .byte_sel  (byte_sel),
      .new_key   (item_key_r),
      .new_tag   (item_tag_r),
      .new_ptr   (item_ptr_r),
      .left_key  (lk),
      .left_tag  (lt),
      .left_ptr  (lp),
      .key_q     (cell_key[j]),
      .tag_q     (cell_tag[j]),
      .ptr_q     (cell_ptr[j]),
      .hit       (hit[j])
    );
  end

  always_comb begin
    pos = POS_W'(SLOTS);
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        pos = POS_W'(j);
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      out_pos_r <= do_clear ? '0 : pos;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;

  // ---------------- checks ----------------
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_BUSY)
    else $error("accepted transaction did not start processing");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_BUSY))
    else $error("result appeared without a transaction in flight");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pos_r <= POS_W'(SLOTS))
    else $error("position beyond overflow slot");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |-> $countones(found[SLOTS+1:1] & ~found[SLOTS:0]) == 1)
    else $error("insert must place the entry in exactly one cell");

endmodule

>>> rtl/snki_cell.sv
module snki_cell #(
  parameter int KEY_W = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  snki_pkg::cell_ctl_t                 ctl,
  input  logic [KEY_W-1:0]                    key_mask,
  input  logic [snki_pkg::BYTE_SEL_W-1:0]     byte_sel,
  input  logic [KEY_W-1:0]                    new_key,
  input  logic [snki_pkg::TAG_W-1:0]          new_tag,
  input  logic [snki_pkg::PTR_W-1:0]          new_ptr,
  input  logic [KEY_W-1:0]                    left_key,
  input  logic [snki_pkg::TAG_W-1:0]          left_tag,
  input  logic [snki_pkg::PTR_W-1:0]          left_ptr,
  output logic [KEY_W-1:0]                    key_q,
  output logic [snki_pkg::TAG_W-1:0]          tag_q,
  output logic [snki_pkg::PTR_W-1:0]          ptr_q,
  output logic                                hit
);
  import snki_pkg::*;

  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic [KEY_W-1:0]    key_m;
  logic [IN_KEY_W-1:0] key_wide;
  logic [7:0]          first_byte;

  // stored keys are re-masked so a key length change applies to old entries
  always_comb begin
    key_m      = key_r & key_mask;
    key_wide   = IN_KEY_W'(key_m);
    first_byte = key_wide[{byte_sel, 3'b000} +: 8];
    hit        = (first_byte == 8'd0) ||
                 ({key_m, tag_r, ptr_r} > {new_key, new_tag, new_ptr});
  end

  always_comb begin
    key_nxt = key_r;
    tag_nxt = tag_r;
    ptr_nxt = ptr_r;
    if (ctl.clear) begin
      key_nxt = '0;
      tag_nxt = '0;
      ptr_nxt = '0;
    end else if (ctl.take_left) begin
      key_nxt = left_key;
      tag_nxt = left_tag;
      ptr_nxt = left_ptr;
    end else if (ctl.load_new) begin
      key_nxt = new_key;
      tag_nxt = new_tag;
      ptr_nxt = new_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      tag_r <= '0;
      ptr_r <= '0;
    end else begin
      key_r <= key_nxt;
      tag_r <= tag_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  assign key_q = key_r;
  assign tag_q = tag_r;
  assign ptr_q = ptr_r;

endmodule
